// ===== rtl/pgr_pkg.sv =====
// pgr_pkg: shared types, widths and helpers for the palette gradient ramp
// no dependencies; imported by every module of the block
`default_nettype none

package pgr_pkg;

    localparam int INDEX_W   = 4;
    localparam int COLOR_W   = 16;
    localparam int LEVEL_W   = 8;
    localparam int DEPTH_W   = 4;
    localparam int LANES     = 3;

    // restoring divider runs one quotient bit per cycle over a color word
    localparam int DIV_STEPS = COLOR_W;

    // full scale of a color component, and twice that for the level divide
    localparam logic [24:0] FULL_SCALE = 25'd65535;
    localparam logic [24:0] QUANT_DEN  = 25'd131070;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd3;
    localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 4'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 4'd8;

    localparam int DEF_PALETTE_ENTRIES = 16;
    localparam int DEF_QUEUE_DEPTH     = 2;

    // one accepted ramp request, endpoints already in rising index order
    typedef struct packed {
        logic [INDEX_W-1:0]            lo_index;
        logic [INDEX_W-1:0]            span;
        logic [LANES-1:0][COLOR_W-1:0] lo_color;
        logic [LANES-1:0][COLOR_W-1:0] hi_color;
    } pgr_job_t;

    // number of display levels for a depth setting, depth clamped to 1..8
    function automatic logic [LEVEL_W-1:0] depth_levels(input logic [DEPTH_W-1:0] depth);
        logic [DEPTH_W-1:0] d;
        logic [LEVEL_W:0]   full;
        d = depth;
        if (d < DEPTH_MIN)
        begin
            d = DEPTH_MIN;
        end
        if (d > DEPTH_MAX)
        begin
            d = DEPTH_MAX;
        end
        full = (LEVEL_W+1)'(1) << d;
        return LEVEL_W'(full - (LEVEL_W+1)'(1));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pgr_front.sv =====
// pgr_front: takes request beats, orders the endpoints and drops requests
// that are out of range or have no interior entries; depends on pgr_pkg
`default_nettype none

module pgr_front
    import pgr_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
)
(
    input  wire logic                            push,
    input  wire logic                            q_full,
    input  wire logic [INDEX_W-1:0]              first_index,
    input  wire logic [INDEX_W-1:0]              second_index,
    input  wire logic [LANES-1:0][COLOR_W-1:0]   start_color,
    input  wire logic [LANES-1:0][COLOR_W-1:0]   end_color,
    output logic                                 q_push,
    output pgr_job_t                             job
);

    logic in_range;
    logic swap;
    logic wide_enough;

    // range check against the palette size
    assign in_range = (32'(first_index) < PALETTE_ENTRIES)
                   && (32'(second_index) < PALETTE_ENTRIES);

    // put the endpoints in rising order
    assign swap = (second_index < first_index);

    always_comb
    begin
        if (swap)
        begin
            job.lo_index = second_index;
            job.span     = first_index - second_index;
            job.lo_color = end_color;
            job.hi_color = start_color;
        end
        else
        begin
            job.lo_index = first_index;
            job.span     = second_index - first_index;
            job.lo_color = start_color;
            job.hi_color = end_color;
        end
    end

    // at least one interior entry needs a span of two
    assign wide_enough = (job.span >= INDEX_W'(2));

    assign q_push = push && !q_full && in_range && wide_enough;

endmodule

`default_nettype wire

// ===== rtl/pgr_queue.sv =====
// pgr_queue: short request queue between the front and the back
// depends on pgr_pkg for the request type
`default_nettype none

module pgr_queue
    import pgr_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_en,
    input  wire pgr_job_t wr_data,
    input  wire logic     rd_en,
    output pgr_job_t      rd_data,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pgr_job_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pgr_back.sv =====
// pgr_back: walks the interior entries of one request, stepping each color
// with a quotient/remainder accumulator and quantizing it; depends on pgr_pkg
`default_nettype none

module pgr_back
    import pgr_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           job_valid,
    input  wire pgr_job_t                       job,
    output logic                                job_pop,
    input  wire logic [LEVEL_W-1:0]             levels,
    input  wire logic                           pop,
    output logic                                empty,
    output logic [INDEX_W-1:0]                  entry_index,
    output logic [LANES-1:0][COLOR_W-1:0]       ramp,
    output logic [LANES-1:0][LEVEL_W-1:0]       level,
    output logic                                last_entry
);

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam int ACC_W = COLOR_W + 2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_PREP  = 6'b000100,
        S_STEP  = 6'b001000,
        S_QUANT = 6'b010000,
        S_EMIT  = 6'b100000
    } back_state_t;

    back_state_t              state_reg, state_next;
    logic [INDEX_W-1:0]       lo_idx_reg, lo_idx_next;
    logic [INDEX_W-1:0]       span_reg, span_next;
    logic [INDEX_W-1:0]       k_reg, k_next;
    logic [CNT_W-1:0]         bit_cnt_reg, bit_cnt_next;
    logic                     neg_reg [LANES];
    logic                     neg_next [LANES];
    logic [COLOR_W-1:0]       quo_reg [LANES];
    logic [COLOR_W-1:0]       quo_next [LANES];
    logic [4:0]               rem_reg [LANES];
    logic [4:0]               rem_next [LANES];
    logic signed [ACC_W-1:0]  stq_reg [LANES];
    logic signed [ACC_W-1:0]  stq_next [LANES];
    logic [4:0]               str_reg [LANES];
    logic [4:0]               str_next [LANES];
    logic signed [ACC_W-1:0]  acc_reg [LANES];
    logic signed [ACC_W-1:0]  acc_next [LANES];
    logic [4:0]               frac_reg [LANES];
    logic [4:0]               frac_next [LANES];
    logic [COLOR_W-1:0]       ramp_reg [LANES];
    logic [COLOR_W-1:0]       ramp_next [LANES];
    logic [24:0]              y_reg [LANES];
    logic [24:0]              y_next [LANES];

    logic                     out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]       out_index_reg, out_index_next;
    logic [COLOR_W-1:0]       out_ramp_reg [LANES];
    logic [COLOR_W-1:0]       out_ramp_next [LANES];
    logic [LEVEL_W-1:0]       out_level_reg [LANES];
    logic [LEVEL_W-1:0]       out_level_next [LANES];
    logic                     out_last_reg, out_last_next;

    logic                     slot_free;
    logic                     is_last;
    logic [5:0]               two_span;

    assign slot_free = !out_valid_reg || pop;
    assign is_last   = (k_reg == span_reg - INDEX_W'(1));
    assign two_span  = {1'b0, span_reg, 1'b0};

    always_comb
    begin
        logic [5:0]               rem_sh;
        logic                     ge;
        logic signed [ACC_W-1:0]  sum;
        logic [5:0]               t;
        logic signed [ACC_W-1:0]  acc_new;
        logic [23:0]              prod;
        logic [7:0]               t8;
        logic [24:0]              base;
        logic [24:0]              rr;
        logic [8:0]               lvl9;

        rem_sh         = '0;
        ge             = 1'b0;
        sum            = '0;
        t              = '0;
        acc_new        = '0;
        prod           = '0;
        t8             = '0;
        base           = '0;
        rr             = '0;
        lvl9           = '0;
        state_next     = state_reg;
        lo_idx_next    = lo_idx_reg;
        span_next      = span_reg;
        k_next         = k_reg;
        bit_cnt_next   = bit_cnt_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        job_pop        = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            neg_next[i]       = neg_reg[i];
            quo_next[i]       = quo_reg[i];
            rem_next[i]       = rem_reg[i];
            stq_next[i]       = stq_reg[i];
            str_next[i]       = str_reg[i];
            acc_next[i]       = acc_reg[i];
            frac_next[i]      = frac_reg[i];
            ramp_next[i]      = ramp_reg[i];
            y_next[i]         = y_reg[i];
            out_ramp_next[i]  = out_ramp_reg[i];
            out_level_next[i] = out_level_reg[i];
        end

        // result beat taken by the consumer
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            // load a request: color difference magnitude goes to the divider
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop      = 1'b1;
                    lo_idx_next  = job.lo_index;
                    span_next    = job.span;
                    bit_cnt_next = CNT_W'(DIV_STEPS - 1);
                    for (int i = 0; i < LANES; i++)
                    begin
                        neg_next[i]  = job.hi_color[i] < job.lo_color[i];
                        quo_next[i]  = neg_next[i] ? job.lo_color[i] - job.hi_color[i]
                                                   : job.hi_color[i] - job.lo_color[i];
                        rem_next[i]  = '0;
                        acc_next[i]  = signed'({2'b00, job.lo_color[i]});
                        frac_next[i] = {1'b0, job.span};
                    end
                    state_next = S_DIV;
                end
            end
            // restoring divide of |hi - lo| by span, one bit per cycle
            S_DIV:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    rem_sh       = {rem_reg[i], quo_reg[i][COLOR_W-1]};
                    ge           = rem_sh >= {2'b00, span_reg};
                    rem_next[i]  = ge ? 5'(rem_sh - {2'b00, span_reg}) : rem_sh[4:0];
                    quo_next[i]  = {quo_reg[i][COLOR_W-2:0], ge};
                end
                if (bit_cnt_reg == '0)
                begin
                    state_next = S_PREP;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - CNT_W'(1);
                end
            end
            // floor-divided step of 2*diff over 2*span, signed
            S_PREP:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    if (!neg_reg[i])
                    begin
                        stq_next[i] = signed'({2'b00, quo_reg[i]});
                        str_next[i] = {rem_reg[i][3:0], 1'b0};
                    end
                    else if (rem_reg[i] == '0)
                    begin
                        stq_next[i] = -signed'({2'b00, quo_reg[i]});
                        str_next[i] = '0;
                    end
                    else
                    begin
                        stq_next[i] = -(signed'({2'b00, quo_reg[i]}) + ACC_W'(1));
                        str_next[i] = 5'({span_reg - rem_reg[i][3:0], 1'b0});
                    end
                end
                k_next     = INDEX_W'(1);
                state_next = S_STEP;
            end
            // advance one entry: add step, carry remainder overflow
            S_STEP:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    sum = acc_reg[i] + stq_reg[i];
                    t   = {1'b0, frac_reg[i]} + {1'b0, str_reg[i]};
                    if (t >= two_span)
                    begin
                        acc_new      = sum + ACC_W'(1);
                        frac_next[i] = 5'(t - two_span);
                    end
                    else
                    begin
                        acc_new      = sum;
                        frac_next[i] = t[4:0];
                    end
                    acc_next[i] = acc_new;
                    if (acc_new < 0)
                    begin
                        ramp_next[i] = '0;
                    end
                    else if (acc_new > signed'(ACC_W'(FULL_SCALE)))
                    begin
                        ramp_next[i] = '1;
                    end
                    else
                    begin
                        ramp_next[i] = acc_new[COLOR_W-1:0];
                    end
                end
                state_next = S_QUANT;
            end
            // level numerator 2*L*v + full scale
            S_QUANT:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    prod      = ramp_reg[i] * levels;
                    y_next[i] = {prod, 1'b0} + FULL_SCALE;
                end
                state_next = S_EMIT;
            end
            // divide by twice full scale: shift estimate plus one correction
            S_EMIT:
            begin
                if (slot_free)
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        t8   = y_reg[i][24:17];
                        base = {t8, 17'd0} - {16'd0, t8, 1'b0};
                        rr   = y_reg[i] - base;
                        lvl9 = (rr >= QUANT_DEN) ? {1'b0, t8} + 9'd1 : {1'b0, t8};
                        out_level_next[i] = (lvl9 > {1'b0, levels}) ? levels : lvl9[7:0];
                        out_ramp_next[i]  = ramp_reg[i];
                    end
                    out_valid_next = 1'b1;
                    out_index_next = lo_idx_reg + k_reg;
                    out_last_next  = is_last;
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + INDEX_W'(1);
                        state_next = S_STEP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and result registers
    always_ff @(posedge clk)
    begin
        lo_idx_reg    <= lo_idx_next;
        span_reg      <= span_next;
        k_reg         <= k_next;
        bit_cnt_reg   <= bit_cnt_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
        for (int i = 0; i < LANES; i++)
        begin
            neg_reg[i]       <= neg_next[i];
            quo_reg[i]       <= quo_next[i];
            rem_reg[i]       <= rem_next[i];
            stq_reg[i]       <= stq_next[i];
            str_reg[i]       <= str_next[i];
            acc_reg[i]       <= acc_next[i];
            frac_reg[i]      <= frac_next[i];
            ramp_reg[i]      <= ramp_next[i];
            y_reg[i]         <= y_next[i];
            out_ramp_reg[i]  <= out_ramp_next[i];
            out_level_reg[i] <= out_level_next[i];
        end
    end

    // result ports
    assign empty       = !out_valid_reg;
    assign entry_index = out_index_reg;
    assign last_entry  = out_last_reg;
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            ramp[i]  = out_ramp_reg[i];
            level[i] = out_level_reg[i];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/palette_gradient_ramp_core.sv =====
// palette_gradient_ramp_core: top level of the palette gradient ramp
// depends on pgr_pkg, pgr_front, pgr_queue, pgr_back
//
//   channel   direction  handshake            payload
//   request   in         push / full          first_index .. end_blue
//   entry     out        empty / pop          entry_index .. last_entry
//   depth     in         cfg_valid/cfg_ready  color_depth
//
// in the back end a restoring divide per color sets the step, then each entry
// needs one step, one level multiply and one correction state
// requests queue in front of the back end; full rises when the queue holds
// its depth; empty stays low while an entry waits, and a waiting entry
// stalls the walk. reset clears queue, walker and the result valid flag
`default_nettype none

module palette_gradient_ramp_core
    import pgr_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
    parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [INDEX_W-1:0]   first_index,
    input  wire logic [INDEX_W-1:0]   second_index,
    input  wire logic [COLOR_W-1:0]   start_red,
    input  wire logic [COLOR_W-1:0]   start_green,
    input  wire logic [COLOR_W-1:0]   start_blue,
    input  wire logic [COLOR_W-1:0]   end_red,
    input  wire logic [COLOR_W-1:0]   end_green,
    input  wire logic [COLOR_W-1:0]   end_blue,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [INDEX_W-1:0]        entry_index,
    output logic [COLOR_W-1:0]        ramp_red,
    output logic [COLOR_W-1:0]        ramp_green,
    output logic [COLOR_W-1:0]        ramp_blue,
    output logic [LEVEL_W-1:0]        level_red,
    output logic [LEVEL_W-1:0]        level_green,
    output logic [LEVEL_W-1:0]        level_blue,
    output logic                      last_entry,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [DEPTH_W-1:0]   color_depth
);

    logic [DEPTH_W-1:0]            depth_reg, depth_next;
    logic [LEVEL_W-1:0]            levels;
    logic [LANES-1:0][COLOR_W-1:0] start_color;
    logic [LANES-1:0][COLOR_W-1:0] end_color;
    logic [LANES-1:0][COLOR_W-1:0] ramp;
    logic [LANES-1:0][LEVEL_W-1:0] level;
    pgr_job_t                      front_job;
    pgr_job_t                      back_job;
    logic                          q_push;
    logic                          q_pop;
    logic                          q_full;
    logic                          q_empty;

    // depth register, always writable
    assign cfg_ready = 1'b1;
    assign depth_next = (cfg_valid && cfg_ready) ? color_depth : depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_RESET;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    assign levels = depth_levels(depth_reg);

    // color lanes: red, green, blue
    assign start_color = {start_blue, start_green, start_red};
    assign end_color   = {end_blue, end_green, end_red};

    pgr_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .push         (push),
        .q_full       (q_full),
        .first_index  (first_index),
        .second_index (second_index),
        .start_color  (start_color),
        .end_color    (end_color),
        .q_push       (q_push),
        .job          (front_job)
    );

    pgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (front_job),
        .rd_en   (q_pop),
        .rd_data (back_job),
        .full    (q_full),
        .empty   (q_empty)
    );

    pgr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (!q_empty),
        .job         (back_job),
        .job_pop     (q_pop),
        .levels      (levels),
        .pop         (pop),
        .empty       (empty),
        .entry_index (entry_index),
        .ramp        (ramp),
        .level       (level),
        .last_entry  (last_entry)
    );

    assign full        = q_full;
    assign ramp_red    = ramp[0];
    assign ramp_green  = ramp[1];
    assign ramp_blue   = ramp[2];
    assign level_red   = level[0];
    assign level_green = level[1];
    assign level_blue  = level[2];

`ifndef NO_ASSERTIONS
    // the back end only takes a request the queue actually holds
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("request taken from an empty queue");

    // the queue never reports full and empty together
    assert property (@(posedge clk) disable iff (!rst_n) !(q_full && q_empty))
        else $error("queue full and empty at once");

    // an interior entry never lands on palette index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (entry_index != '0))
        else $error("entry at index zero");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking bench for palette_gradient_ramp_core, predicts every ramp entry
// depends on rtl/pgr_pkg.sv and rtl/palette_gradient_ramp_core.sv
// directed ramps, depth settings, input stall under long pop hold-off, random ramps
`default_nettype none

module tb
    import pgr_pkg::*;
();

    localparam int ENTRY_COUNT  = DEF_PALETTE_ENTRIES;
    localparam int DRAIN_CYCLES = 90;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_RAMPS = 90;

    // one ramp request as offered on the push side
    typedef struct packed {
        logic [INDEX_W-1:0]            first;
        logic [INDEX_W-1:0]            second;
        logic [LANES-1:0][COLOR_W-1:0] start_color;
        logic [LANES-1:0][COLOR_W-1:0] end_color;
    } ramp_request_t;

    // one interior palette entry, lane 0 red, 1 green, 2 blue
    typedef struct packed {
        logic [INDEX_W-1:0]            index;
        logic [LANES-1:0][COLOR_W-1:0] ramp;
        logic [LANES-1:0][LEVEL_W-1:0] level;
        logic                          last;
    } ramp_entry_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [INDEX_W-1:0]   first_index = '0;
    logic [INDEX_W-1:0]   second_index = '0;
    logic [COLOR_W-1:0]   start_red = '0;
    logic [COLOR_W-1:0]   start_green = '0;
    logic [COLOR_W-1:0]   start_blue = '0;
    logic [COLOR_W-1:0]   end_red = '0;
    logic [COLOR_W-1:0]   end_green = '0;
    logic [COLOR_W-1:0]   end_blue = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [INDEX_W-1:0]   entry_index;
    logic [COLOR_W-1:0]   ramp_red;
    logic [COLOR_W-1:0]   ramp_green;
    logic [COLOR_W-1:0]   ramp_blue;
    logic [LEVEL_W-1:0]   level_red;
    logic [LEVEL_W-1:0]   level_green;
    logic [LEVEL_W-1:0]   level_blue;
    logic                 last_entry;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [DEPTH_W-1:0]   color_depth = DEPTH_RESET;

    // predicted entries in output order, and the depth the block holds
    ramp_entry_t          pending_entries[$];
    logic [DEPTH_W-1:0]   model_depth = DEPTH_RESET;
    int                   mismatch_count = 0;
    int                   cycle_count = 0;

    // pop side pacing
    int                   hold_request = 0;
    int                   hold_left = 0;
    int                   pop_wait = 0;
    int                   pop_run = 0;

    // push side pacing
    bit                   no_idle = 1'b0;

    palette_gradient_ramp_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .first_index  (first_index),
        .second_index (second_index),
        .start_red    (start_red),
        .start_green  (start_green),
        .start_blue   (start_blue),
        .end_red      (end_red),
        .end_green    (end_green),
        .end_blue     (end_blue),
        .empty        (empty),
        .pop          (pop),
        .entry_index  (entry_index),
        .ramp_red     (ramp_red),
        .ramp_green   (ramp_green),
        .ramp_blue    (ramp_blue),
        .level_red    (level_red),
        .level_green  (level_green),
        .level_blue   (level_blue),
        .last_entry   (last_entry),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .color_depth  (color_depth)
    );

    // clock
    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ramp prediction: lerp with round-half-up, then quantize to 2^depth - 1 levels
    function automatic void predict_ramp(ramp_request_t rq);
        longint unsigned               lo_i, hi_i, span, k, depth, levels, num, v, q;
        logic [LANES-1:0][COLOR_W-1:0] lo_c, hi_c;
        ramp_entry_t                   ent;
        lo_i = rq.first;
        hi_i = rq.second;
        lo_c = rq.start_color;
        hi_c = rq.end_color;
        if (lo_i >= ENTRY_COUNT || hi_i >= ENTRY_COUNT)
        begin
            return;
        end
        // reversed endpoints swap along with their colors
        if (hi_i < lo_i)
        begin
            lo_i = rq.second;
            hi_i = rq.first;
            lo_c = rq.end_color;
            hi_c = rq.start_color;
        end
        span = hi_i - lo_i;
        if (span < 2)
        begin
            return;
        end
        depth = model_depth;
        if (depth < 1)
        begin
            depth = 1;
        end
        if (depth > 8)
        begin
            depth = 8;
        end
        levels = (64'd1 << depth) - 1;
        for (k = 1; k < span; k++)
        begin
            ent.index = INDEX_W'(lo_i + k);
            for (int c = 0; c < LANES; c++)
            begin
                num = longint'(lo_c[c]) * (span - k) + longint'(hi_c[c]) * k;
                v = (2 * num + span) / (2 * span);
                if (v > 65535)
                begin
                    v = 65535;
                end
                q = (2 * levels * v + 65535) / 131070;
                if (q > levels)
                begin
                    q = levels;
                end
                ent.ramp[c]  = COLOR_W'(v);
                ent.level[c] = LEVEL_W'(q);
            end
            ent.last = (k == span - 1);
            pending_entries.push_back(ent);
        end
    endfunction

    function automatic ramp_request_t make_request(int a, int b,
        int sr, int sg, int sb, int er, int eg, int eb);
        ramp_request_t rq;
        rq.first          = INDEX_W'(a);
        rq.second         = INDEX_W'(b);
        rq.start_color[0] = COLOR_W'(sr);
        rq.start_color[1] = COLOR_W'(sg);
        rq.start_color[2] = COLOR_W'(sb);
        rq.end_color[0]   = COLOR_W'(er);
        rq.end_color[1]   = COLOR_W'(eg);
        rq.end_color[2]   = COLOR_W'(eb);
        return rq;
    endfunction

    // mostly uniform, sometimes a corner value
    function automatic logic [COLOR_W-1:0] random_color();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8)
        begin
            return COLOR_W'($urandom);
        end
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'h7fff;
            default: return 16'h8000;
        endcase
    endfunction

    // well formed: endpoints at least two apart; otherwise adjacent or equal
    function automatic ramp_request_t random_request(bit well_formed);
        ramp_request_t rq;
        int            a, b;
        a = $urandom_range(0, ENTRY_COUNT - 1);
        if (well_formed)
        begin
            do
            begin
                b = $urandom_range(0, ENTRY_COUNT - 1);
            end
            while (b - a < 2 && a - b < 2);
        end
        else
        begin
            b = a + $urandom_range(0, 2) - 1;
            if (b < 0)
            begin
                b = 0;
            end
            if (b > ENTRY_COUNT - 1)
            begin
                b = ENTRY_COUNT - 1;
            end
        end
        rq.first  = INDEX_W'(a);
        rq.second = INDEX_W'(b);
        for (int c = 0; c < LANES; c++)
        begin
            rq.start_color[c] = random_color();
            rq.end_color[c]   = random_color();
        end
        return rq;
    endfunction

    // one request beat; returns at the edge where it was taken, push left high
    task automatic send_request(ramp_request_t rq);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        first_index  <= rq.first;
        second_index <= rq.second;
        start_red    <= rq.start_color[0];
        start_green  <= rq.start_color[1];
        start_blue   <= rq.start_color[2];
        end_red      <= rq.end_color[0];
        end_green    <= rq.end_color[1];
        end_blue     <= rq.end_color[2];
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        predict_ramp(rq);
    endtask

    // all entries out, then let a ramp that makes none run through
    task automatic wait_idle();
        while (pending_entries.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // depth write, only once the block has gone quiet
    task automatic set_depth(logic [DEPTH_W-1:0] d);
        push <= 1'b0;
        wait_idle();
        cfg_valid   <= 1'b1;
        color_depth <= d;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        model_depth = d;
    endtask

    // pop pacing: random runs and gaps, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (pop_wait > 0)
        begin
            pop_wait--;
            pop <= 1'b0;
        end
        else if (pop_run > 0)
        begin
            pop_run--;
            pop <= 1'b1;
        end
        else
        begin
            pop_run  = $urandom_range(0, 60);
            pop_wait = pick_gap();
            pop <= 1'b1;
        end
    end

    task automatic check_field(string label, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // compare each entry beat with the oldest prediction
    always @(posedge clk)
    begin
        ramp_entry_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_entries.size() == 0)
            begin
                $display("%0t: unexpected entry, expected none actual index %0h", $time,
                    entry_index);
                mismatch_count++;
            end
            else
            begin
                want = pending_entries.pop_front();
                check_field("entry_index", want.index, entry_index);
                check_field("ramp_red", want.ramp[0], ramp_red);
                check_field("ramp_green", want.ramp[1], ramp_green);
                check_field("ramp_blue", want.ramp[2], ramp_blue);
                check_field("level_red", want.level[0], level_red);
                check_field("level_green", want.level[1], level_green);
                check_field("level_blue", want.level[2], level_blue);
                check_field("last_entry", want.last, last_entry);
            end
        end
    end

    // reset depth: full span, reversal, ties, too close, saturated colors
    task automatic test_directed_ramps();
        send_request(make_request(0, 15, 0, 0, 0, 65535, 65535, 65535));
        send_request(make_request(15, 0, 65535, 65535, 65535, 0, 0, 0));
        send_request(make_request(4, 6, 0, 65535, 1, 65535, 0, 0));
        send_request(make_request(7, 8, 100, 200, 300, 400, 500, 600));
        send_request(make_request(9, 9, 65535, 0, 65535, 0, 65535, 0));
        send_request(make_request(8, 7, 1, 2, 3, 4, 5, 6));
        send_request(make_request(0, 2, 65535, 65535, 65535, 65535, 65535, 65535));
        send_request(make_request(13, 3, 12345, 40000, 65535, 0, 999, 32768));
        send_request(make_request(1, 14, 32767, 32768, 0, 32768, 32767, 65535));
        send_request(make_request(10, 5, 0, 1, 65534, 65535, 2, 3));
    endtask

    // depth extremes and the clamped settings
    task automatic test_depth_extremes();
        set_depth(DEPTH_MIN);
        send_request(make_request(0, 15, 0, 65535, 21845, 65535, 0, 43690));
        send_request(make_request(5, 2, 32767, 32768, 16384, 49151, 0, 65535));
        set_depth(DEPTH_MAX);
        send_request(make_request(0, 15, 0, 0, 0, 65535, 65535, 65535));
        send_request(make_request(15, 0, 128, 257, 65279, 65535, 32896, 0));
        set_depth(4'd0);
        send_request(make_request(1, 4, 0, 65535, 30000, 65535, 0, 35000));
        set_depth(4'd15);
        send_request(make_request(0, 3, 255, 65280, 1, 65535, 0, 65534));
        set_depth(4'd5);
        send_request(make_request(2, 12, 1000, 2000, 3000, 60000, 50000, 40000));
    endtask

    // hold pop off for a long stretch while requests keep coming, so full rises
    task automatic test_input_stall();
        hold_request = 500;
        no_idle = 1'b1;
        for (int n = 0; n < 10; n++)
        begin
            send_request(random_request(1'b1));
        end
        no_idle = 1'b0;
    endtask

    // random ramps, mostly well formed, depth changed every few dozen
    task automatic test_random_ramps();
        int formed;
        formed = 0;
        while (formed < RANDOM_RAMPS)
        begin
            if (formed % 25 == 24)
            begin
                set_depth(DEPTH_W'($urandom_range(0, 15)));
            end
            if (formed % 20 == 0)
            begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < 85)
            begin
                send_request(random_request(1'b1));
                formed++;
            end
            else
            begin
                send_request(random_request(1'b0));
            end
        end
        no_idle = 1'b0;
    endtask

    // sequence
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);
        test_directed_ramps();
        test_depth_extremes();
        test_input_stall();
        test_random_ramps();
        push <= 1'b0;
        wait_idle();
        if (mismatch_count == 0 && pending_entries.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
